/* src/tccw_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants of the text console character writer
package tccw_pkg;

	localparam int COLUMNS_DEF     = 80;
	localparam int TEXT_ROWS_DEF   = 24;
	localparam int STORE_DEPTH_DEF = 2048;

	localparam int MODE_W   = 1;
	localparam int CHAR_W   = 9;
	localparam int ADDR_W   = 11;
	localparam int CURSOR_W = 11;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_FILTER_ON = 1'd1;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 9'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 9'h100;
	localparam logic [CHAR_W-1:0] CH_ESC       = 9'd27;
	localparam logic [CHAR_W-1:0] CH_LBRACKET  = 9'd91;
	localparam logic [CHAR_W-1:0] CH_DIGIT_LO  = 9'd48;
	localparam logic [CHAR_W-1:0] CH_DIGIT_HI  = 9'd57;
	localparam logic [CHAR_W-1:0] CH_SEMICOLON = 9'd59;
	localparam logic [CHAR_W-1:0] CH_LETTER_M  = 9'd109;
	localparam logic [7:0]        CH_SPACE     = 8'h20;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] char_code;
		logic [ADDR_W-1:0] read_addr;
	} req_t;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_pos;
		logic [CELL_W-1:0]   cell_data;
		logic                swallowed;
	} res_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_READ_OUT,
		ST_PUT,
		ST_COPY,
		ST_FILL,
		ST_MARK
	} state_t;

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_SEEN,
		ESC_PARAMS,
		ESC_DONE
	} esc_phase_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CHAR,
		WR_SPACE,
		WR_COPY,
		WR_ZERO
	} wr_kind_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_POS,
		IDX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_READ,
		EMIT_PUT,
		EMIT_SWALLOW
	} emit_t;

	typedef enum logic {
		RD_ITEM,
		RD_COPY
	} rd_sel_t;

	typedef struct packed {
		logic     latch;
		logic     put_step;
		wr_kind_t wr_kind;
		rd_sel_t  rd_sel;
		idx_op_t  idx_op;
		emit_t    emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start_read;
		logic swallow;
		logic scroll;
		logic copy_last;
		logic fill_last;
		logic init_last;
	} ctrl_status_t;

endpackage

/* src/text_console_char_writer_core.sv */
`timescale 1ns / 1ps
// top level of the text console character writer
// sequence: a read passes READ and READ_OUT before the registered done strobe, a printed
//   character PUT and MARK, a swallowed escape character PUT only; a scroll adds COPY, then FILL (row copy, then clear)
// a new request is taken only in the idle state, with busy low; a scroll stalls input
// reset: cursor and filter phase clear at once, the attribute goes to ATTR_RESET, the filter is on; the cell store
//   is then swept to zero with busy high; results carry a one-cycle strobe, the receiver cannot stall
module text_console_char_writer_core #(
	parameter int COLUMNS     = tccw_pkg::COLUMNS_DEF,
	parameter int TEXT_ROWS   = tccw_pkg::TEXT_ROWS_DEF,
	parameter int STORE_DEPTH = tccw_pkg::STORE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  tccw_pkg::req_t                 request,
	output logic                           done,
	output tccw_pkg::res_t                 result,
	input  logic                           cfg_wr_en,
	input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tccw_pkg::ATTR_W-1:0]    cfg_data
);
	import tccw_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	tccw_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	tccw_datapath #(
		.COLUMNS     (COLUMNS),
		.TEXT_ROWS   (TEXT_ROWS),
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result),
		.done      (done)
	);

endmodule

/* src/tccw_controller.sv */
`timescale 1ns / 1ps
// sequencing state machine of the text console character writer
module tccw_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  tccw_pkg::ctrl_status_t status,
	output tccw_pkg::ctrl_cmd_t   cmd
);
	import tccw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (status.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = status.start_read ? ST_READ : ST_PUT;
				end
			end
			ST_READ:     state_d = ST_READ_OUT;
			ST_READ_OUT: state_d = ST_IDLE;
			ST_PUT: begin
				if (status.swallow) begin
					state_d = ST_IDLE;
				end else if (status.scroll) begin
					state_d = ST_COPY;
				end else begin
					state_d = ST_MARK;
				end
			end
			ST_COPY: begin
				if (status.copy_last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (status.fill_last) begin
					state_d = ST_MARK;
				end
			end
			ST_MARK:     state_d = ST_IDLE;
			default:     state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.wr_kind  = WR_NONE;
		cmd.rd_sel   = RD_ITEM;
		cmd.idx_op   = IDX_HOLD;
		cmd.emit     = EMIT_NONE;
		busy         = 1'b1;
		case (state_q)
			ST_INIT: begin
				cmd.wr_kind = WR_ZERO;
				cmd.idx_op  = IDX_INC;
			end
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.latch  = start;
				cmd.idx_op = IDX_ZERO;
			end
			ST_READ: begin
			end
			ST_READ_OUT: begin
				cmd.emit = EMIT_READ;
			end
			ST_PUT: begin
				cmd.put_step = 1'b1;
				cmd.wr_kind  = WR_CHAR;
				if (status.swallow) begin
					cmd.emit = EMIT_SWALLOW;
				end
			end
			ST_COPY: begin
				cmd.rd_sel  = RD_COPY;
				cmd.wr_kind = WR_COPY;
				cmd.idx_op  = status.copy_last ? IDX_POS : IDX_INC;
			end
			ST_FILL: begin
				cmd.wr_kind = WR_ZERO;
				cmd.idx_op  = IDX_INC;
			end
			ST_MARK: begin
				cmd.wr_kind = WR_SPACE;
				cmd.emit    = EMIT_PUT;
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/tccw_datapath.sv */
`timescale 1ns / 1ps
// cell store, cursor, escape filter and result register of the console writer
module tccw_datapath #(
	parameter int COLUMNS     = tccw_pkg::COLUMNS_DEF,
	parameter int TEXT_ROWS   = tccw_pkg::TEXT_ROWS_DEF,
	parameter int STORE_DEPTH = tccw_pkg::STORE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tccw_pkg::req_t                       request,
	input  logic                                 cfg_wr_en,
	input  logic [tccw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tccw_pkg::ATTR_W-1:0]          cfg_data,
	input  tccw_pkg::ctrl_cmd_t                  cmd,
	output tccw_pkg::ctrl_status_t               status,
	output tccw_pkg::res_t                       result,
	output logic                                 done
);
	import tccw_pkg::*;

	localparam int SCREEN = COLUMNS * TEXT_ROWS;
	localparam int CW     = $clog2(SCREEN);
	localparam int COLW   = $clog2(COLUMNS);
	localparam int ROWW   = $clog2(TEXT_ROWS);
	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int SPAN   = (STORE_DEPTH > SCREEN) ? STORE_DEPTH : SCREEN;
	localparam int IW     = $clog2(SPAN + 1);

	logic [CELL_W-1:0] mem [STORE_DEPTH];

	req_t              item_q;
	logic [ATTR_W-1:0] attr_q;
	logic              filt_q;
	esc_phase_t        phase_q;
	logic [CW-1:0]     pos_q;
	logic [COLW-1:0]   col_q;
	logic [ROWW-1:0]   row_q;
	logic [IW-1:0]     idx_q;

	logic              wr_en_s1;
	logic              wr_copy_s1;
	logic [IW-1:0]     wr_addr_s1;
	logic [CELL_W-1:0] wr_data_s1;

	logic [CELL_W-1:0] rdata_q;
	logic              rd_ok_q;
	logic [AW-1:0]     rd_addr;
	logic              rd_ok;

	res_t              result_q;
	logic              done_q;

	esc_phase_t        phase_d;
	logic              sw;
	logic              prints;
	logic [CW:0]       pos_n;
	logic [COLW-1:0]   col_n;
	logic [ROWW:0]     row_n;
	logic              scroll;
	logic [CW-1:0]     pos_fin;
	logic [ROWW-1:0]   row_fin;
	logic [IW-1:0]     copy_src;
	logic [31:0]       item_addr_w;
	logic [31:0]       pos_w;
	logic              wr_en_d;
	logic [IW-1:0]     wr_addr_d;
	logic [CELL_W-1:0] wr_data_d;

	// escape filter
	always_comb begin
		phase_d = ESC_IDLE;
		sw      = 1'b0;
		if (filt_q) begin
			if (item_q.char_code == CH_ESC) begin
				phase_d = ESC_SEEN;
			end else if (phase_q == ESC_SEEN && item_q.char_code == CH_LBRACKET) begin
				phase_d = ESC_PARAMS;
			end else if (phase_q == ESC_PARAMS && ((item_q.char_code >= CH_DIGIT_LO &&
					item_q.char_code <= CH_DIGIT_HI) || item_q.char_code == CH_SEMICOLON)) begin
				phase_d = ESC_PARAMS;
			end else if (phase_q == ESC_PARAMS && item_q.char_code == CH_LETTER_M) begin
				phase_d = ESC_DONE;
			end else begin
				phase_d = ESC_IDLE;
			end
			sw = (phase_d != ESC_IDLE);
		end
	end

	assign prints = (item_q.char_code != CH_NEWLINE) && (item_q.char_code != CH_BACKSPACE);

	// cursor step, row and column kept beside the linear position
	always_comb begin
		pos_n = {1'b0, pos_q};
		col_n = col_q;
		row_n = {1'b0, row_q};
		if (item_q.char_code == CH_NEWLINE) begin
			pos_n = (CW+1)'(pos_q) - (CW+1)'(col_q) + (CW+1)'(COLUMNS);
			col_n = '0;
			row_n = (ROWW+1)'(row_q) + 1'b1;
		end else if (item_q.char_code == CH_BACKSPACE) begin
			if (pos_q != '0) begin
				pos_n = (CW+1)'(pos_q) - 1'b1;
				if (col_q == '0) begin
					col_n = COLW'(COLUMNS - 1);
					row_n = (ROWW+1)'(row_q) - 1'b1;
				end else begin
					col_n = col_q - 1'b1;
				end
			end
		end else begin
			pos_n = (CW+1)'(pos_q) + 1'b1;
			if (col_q == COLW'(COLUMNS - 1)) begin
				col_n = '0;
				row_n = (ROWW+1)'(row_q) + 1'b1;
			end else begin
				col_n = col_q + 1'b1;
			end
		end
		scroll  = (row_n == (ROWW+1)'(TEXT_ROWS));
		pos_fin = scroll ? CW'(pos_n - (CW+1)'(COLUMNS)) : CW'(pos_n);
		row_fin = scroll ? ROWW'(TEXT_ROWS - 1) : ROWW'(row_n);
	end

	always_comb begin
		status            = '0;
		status.start_read = request.mode[0];
		status.swallow    = sw;
		status.scroll     = scroll;
		status.copy_last  = (idx_q == IW'(SCREEN - COLUMNS - 1));
		status.fill_last  = (idx_q == IW'(SCREEN - 1));
		status.init_last  = (idx_q == IW'(STORE_DEPTH - 1));
	end

	// read port: either the requested cell or the row below during a scroll
	assign copy_src    = idx_q + IW'(COLUMNS);
	assign item_addr_w = 32'(item_q.read_addr);
	assign pos_w       = 32'(pos_q);

	always_comb begin
		if (cmd.rd_sel == RD_COPY) begin
			rd_addr = copy_src[AW-1:0];
			rd_ok   = (copy_src < IW'(STORE_DEPTH));
		end else begin
			rd_addr = item_addr_w[AW-1:0];
			rd_ok   = (item_addr_w < 32'(SCREEN)) && (item_addr_w < 32'(STORE_DEPTH));
		end
	end

	// write request into the write stage
	always_comb begin
		wr_en_d   = 1'b0;
		wr_addr_d = idx_q;
		wr_data_d = '0;
		case (cmd.wr_kind)
			WR_CHAR: begin
				wr_en_d   = prints && !sw;
				wr_addr_d = IW'(pos_q);
				wr_data_d = {attr_q, item_q.char_code[7:0]};
			end
			WR_SPACE: begin
				wr_en_d   = 1'b1;
				wr_addr_d = IW'(pos_q);
				wr_data_d = {attr_q, CH_SPACE};
			end
			WR_COPY: begin
				wr_en_d = 1'b1;
			end
			WR_ZERO: begin
				wr_en_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en_s1 && wr_addr_s1 < IW'(STORE_DEPTH)) begin
			mem[wr_addr_s1[AW-1:0]] <= wr_copy_s1 ? (rd_ok_q ? rdata_q : '0) : wr_data_s1;
		end
		rdata_q <= mem[rd_addr];
		rd_ok_q <= rd_ok;
	end

	always_ff @(posedge clk) begin
		wr_copy_s1 <= (cmd.wr_kind == WR_COPY);
		wr_addr_s1 <= wr_addr_d;
		wr_data_s1 <= wr_data_d;
		if (cmd.latch) begin
			item_q <= request;
		end
		if (cmd.emit != EMIT_NONE) begin
			result_q.cursor_pos <= pos_w[CURSOR_W-1:0];
			result_q.cell_data  <= (cmd.emit == EMIT_READ && rd_ok_q) ? rdata_q : '0;
			result_q.swallowed  <= (cmd.emit == EMIT_SWALLOW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
			done_q   <= 1'b0;
			attr_q   <= ATTR_RESET;
			filt_q   <= 1'b1;
			phase_q  <= ESC_IDLE;
			pos_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			idx_q    <= '0;
		end else begin
			wr_en_s1 <= wr_en_d;
			done_q   <= (cmd.emit != EMIT_NONE);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TEXT_ATTRIBUTE:   attr_q <= cfg_data;
					REG_ESCAPE_FILTER_ON: filt_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.put_step) begin
				phase_q <= phase_d;
				if (!sw) begin
					pos_q <= pos_fin;
					col_q <= col_n;
					row_q <= row_fin;
				end
			end
			case (cmd.idx_op)
				IDX_ZERO: idx_q <= '0;
				IDX_POS:  idx_q <= IW'(pos_q);
				IDX_INC:  idx_q <= idx_q + 1'b1;
				default:  idx_q <= idx_q;
			endcase
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule
